// ----- hdl/bpgs_pkg.sv -----
// Shared types and constants for the buzzer pulse-group sequencer.
// Used by bpgs_cfg_regs, bpgs_core and the top level; no dependencies.

package bpgs_pkg;

    // Command codes carried by the opcode field
    typedef enum logic [1:0] {
        OP_POLL  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PULSE_ON    = 2'd0,
        CFG_PULSE_GAP   = 2'd1,
        CFG_GROUP_PAUSE = 2'd2,
        CFG_PULSES      = 2'd3
    } cfg_idx_t;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned PULSE_W = 4;
    localparam int unsigned GROUP_W = 8;

    localparam logic [DUR_W-1:0]   PULSE_ON_RST    = 16'd100;
    localparam logic [DUR_W-1:0]   PULSE_GAP_RST   = 16'd100;
    localparam logic [DUR_W-1:0]   GROUP_PAUSE_RST = 16'd500;
    localparam logic [PULSE_W-1:0] PULSES_RST      = 4'd3;
    localparam logic [PULSE_W-1:0] PULSE_MAX       = 4'd15;

    // Timing settings as seen by the sequencer core
    typedef struct packed {
        logic [DUR_W-1:0]   pulse_on_time;
        logic [DUR_W-1:0]   pulse_gap_time;
        logic [DUR_W-1:0]   group_pause_time;
        logic [PULSE_W-1:0] pulses_per_group;
    } cfg_t;

    // One input item
    typedef struct packed {
        op_t                opcode;
        logic [TIME_W-1:0]  now_ms;
        logic [GROUP_W-1:0] group_count;
    } item_t;

    // One result item
    typedef struct packed {
        logic buzzer_on;
        logic output_changed;
        logic pattern_running;
    } result_t;

endpackage

// ----- hdl/bpgs_cfg_regs.sv -----
// Configuration register file for the buzzer pulse-group sequencer.
// Depends on bpgs_pkg for the register indexes, reset values and cfg_t.

module bpgs_cfg_regs
    import bpgs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [DUR_W-1:0]  wr_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;

    // Write the addressed register on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_on_time    <= PULSE_ON_RST;
            cfg_reg.pulse_gap_time   <= PULSE_GAP_RST;
            cfg_reg.group_pause_time <= GROUP_PAUSE_RST;
            cfg_reg.pulses_per_group <= PULSES_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_PULSE_ON:    cfg_reg.pulse_on_time    <= wr_data;
                CFG_PULSE_GAP:   cfg_reg.pulse_gap_time   <= wr_data;
                CFG_GROUP_PAUSE: cfg_reg.group_pause_time <= wr_data;
                CFG_PULSES:      cfg_reg.pulses_per_group <= wr_data[PULSE_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/bpgs_core.sv -----
// Sequencer state and its combinational next-state update for one command, registered on step.
// Depends on bpgs_pkg for op_t, cfg_t, item_t and result_t.

module bpgs_core
    import bpgs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic               running_reg,  running_next;
    logic               drive_reg,    drive_next;
    logic [GROUP_W-1:0] groups_reg,   groups_next;
    logic [PULSE_W-1:0] pulse_reg,    pulse_next;
    logic [TIME_W-1:0]  change_reg,   change_next;

    logic [TIME_W-1:0]  diff;
    logic               due;
    logic [PULSE_W:0]   pulse_inc;
    logic               group_done;
    logic [TIME_W-1:0]  t_on, t_gap, t_pause;

    // Wrap-safe due check and candidate change times
    assign diff      = item.now_ms - change_reg;
    assign due       = running_reg && !diff[TIME_W-1];
    assign pulse_inc = {1'b0, pulse_reg} + {{PULSE_W{1'b0}}, 1'b1};
    assign group_done = (pulse_inc >= {1'b0, cfg.pulses_per_group});
    assign t_on    = item.now_ms + {{(TIME_W-DUR_W){1'b0}}, cfg.pulse_on_time};
    assign t_gap   = item.now_ms + {{(TIME_W-DUR_W){1'b0}}, cfg.pulse_gap_time};
    assign t_pause = item.now_ms + {{(TIME_W-DUR_W){1'b0}}, cfg.group_pause_time};

    // Next state for the current command
    always_comb
    begin
        running_next = running_reg;
        drive_next   = drive_reg;
        groups_next  = groups_reg;
        pulse_next   = pulse_reg;
        change_next  = change_reg;
        unique case (item.opcode)
            OP_POLL:
            begin
                if (due)
                begin
                    if (drive_reg)
                    begin
                        // End of a pulse: drop the output, count the pulse
                        drive_next = 1'b0;
                        pulse_next = pulse_inc[PULSE_W] ? PULSE_MAX : pulse_inc[PULSE_W-1:0];
                        if (group_done)
                        begin
                            if (groups_reg == {{(GROUP_W-1){1'b0}}, 1'b1})
                            begin
                                running_next = 1'b0;
                                groups_next  = '0;
                                pulse_next   = '0;
                                change_next  = '0;
                            end
                            else
                            begin
                                if (groups_reg > {{(GROUP_W-1){1'b0}}, 1'b1})
                                    groups_next = groups_reg - {{(GROUP_W-1){1'b0}}, 1'b1};
                                change_next = t_pause;
                            end
                        end
                        else
                        begin
                            change_next = t_gap;
                        end
                    end
                    else
                    begin
                        // Start of a pulse: wrap the counter after a group
                        if (pulse_reg >= cfg.pulses_per_group)
                            pulse_next = '0;
                        drive_next  = 1'b1;
                        change_next = t_on;
                    end
                end
            end
            OP_START:
            begin
                running_next = 1'b1;
                groups_next  = item.group_count;
                pulse_next   = '0;
                drive_next   = 1'b1;
                change_next  = t_on;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
                groups_next  = '0;
                pulse_next   = '0;
                change_next  = '0;
                drive_next   = 1'b0;
            end
            default: ;
        endcase
    end

    // Result of the current command
    always_comb
    begin
        result.buzzer_on       = drive_next;
        result.output_changed  = drive_next != drive_reg;
        result.pattern_running = running_next;
    end

    // Advance state on each processed command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            drive_reg   <= 1'b0;
            groups_reg  <= '0;
            pulse_reg   <= '0;
            change_reg  <= '0;
        end
        else if (step)
        begin
            running_reg <= running_next;
            drive_reg   <= drive_next;
            groups_reg  <= groups_next;
            pulse_reg   <= pulse_next;
            change_reg  <= change_next;
        end
    end

endmodule

// ----- hdl/buzzer_pulse_group_sequencer.sv -----
// Buzzer pulse-group sequencer, top level: input register, core, result register.
// Each input item passes the input register, is processed by bpgs_core and lands in the
// result register; a held result stalls the input register until out_ready takes it.
// Throughput: one item per cycle while out_ready stays high.
// Reset (rst_n, async, active low) empties both registers, stops any pattern and
// loads the timing defaults. Depends on bpgs_pkg, bpgs_cfg_regs and bpgs_core.

module buzzer_pulse_group_sequencer
    import bpgs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [DUR_W-1:0]    cfg_data,
    // commands
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [GROUP_W-1:0]  group_count,
    // results
    output logic                out_valid,
    input  logic                out_ready,
    output logic                buzzer_on,
    output logic                output_changed,
    output logic                pattern_running
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t core_result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    step;

    assign cfg_ready = 1'b1;

    bpgs_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Process the held item when the result register is free or draining
    assign step     = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || step;

    // Hold the input item valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    // Capture the input item on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.opcode      <= op_t'(opcode);
            item_reg.now_ms      <= now_ms;
            item_reg.group_count <= group_count;
        end
    end

    bpgs_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Hold the result valid flag until the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (step)
            result_valid_reg <= 1'b1;
        else if (out_ready)
            result_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= core_result;
    end

    assign out_valid       = result_valid_reg;
    assign buzzer_on       = result_reg.buzzer_on;
    assign output_changed  = result_reg.output_changed;
    assign pattern_running = result_reg.pattern_running;

endmodule

// ----- bench/buzzer_pulse_group_sequencer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for buzzer_pulse_group_sequencer: directed and random commands,
// random idling on both channels, results checked against an in-bench pattern tracker.
// Depends on bpgs_pkg and the sequencer RTL.

module buzzer_pulse_group_sequencer_tb;
    import bpgs_pkg::*;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 245;
    localparam int unsigned DRAIN_CYCLES = 4;

    // Tracks the buzzer pattern and holds the results still owed by the block
    class pulse_pattern_tracker;
        cfg_t              timing;
        bit                running;
        bit                level;
        bit [GROUP_W-1:0]  groups_left;
        bit [PULSE_W-1:0]  pulse_num;
        bit [TIME_W-1:0]   next_change;
        result_t           expected_levels[$];
        int unsigned       errors;

        function new();
            timing.pulse_on_time    = PULSE_ON_RST;
            timing.pulse_gap_time   = PULSE_GAP_RST;
            timing.group_pause_time = GROUP_PAUSE_RST;
            timing.pulses_per_group = PULSES_RST;
            running     = 1'b0;
            level       = 1'b0;
            groups_left = '0;
            pulse_num   = '0;
            next_change = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [DUR_W-1:0] data);
            case (idx)
                CFG_PULSE_ON:    timing.pulse_on_time    = data;
                CFG_PULSE_GAP:   timing.pulse_gap_time   = data;
                CFG_GROUP_PAUSE: timing.group_pause_time = data;
                CFG_PULSES:      timing.pulses_per_group = data[PULSE_W-1:0];
                default: ;
            endcase
        endfunction

        function void clear_pattern();
            running     = 1'b0;
            groups_left = '0;
            pulse_num   = '0;
            next_change = '0;
        endfunction

        // Advance the pattern by one command and return the expected levels
        function result_t advance_pattern(logic [1:0] op, logic [TIME_W-1:0] now,
                                          logic [GROUP_W-1:0] cnt);
            bit              changed;
            bit [PULSE_W:0]  nxt;
            bit [TIME_W-1:0] diff;
            result_t         res;
            changed = 1'b0;
            case (op)
                OP_POLL:
                begin
                    diff = now - next_change;
                    if (running && !diff[TIME_W-1])
                    begin
                        if (level)
                        begin
                            // end of a pulse: gap, or pause when the group is done, or stop after the last group
                            nxt       = pulse_num + 1'b1;
                            level     = 1'b0;
                            changed   = 1'b1;
                            pulse_num = (nxt > PULSE_MAX) ? PULSE_MAX : nxt[PULSE_W-1:0];
                            if (nxt >= timing.pulses_per_group)
                            begin
                                if (groups_left == 1)
                                    clear_pattern();
                                else
                                begin
                                    if (groups_left > 1)
                                        groups_left--;
                                    next_change = now + timing.group_pause_time;
                                end
                            end
                            else
                                next_change = now + timing.pulse_gap_time;
                        end
                        else
                        begin
                            // start of a pulse, first of a new group if the count ran out
                            if (pulse_num >= timing.pulses_per_group)
                                pulse_num = '0;
                            level       = 1'b1;
                            changed     = 1'b1;
                            next_change = now + timing.pulse_on_time;
                        end
                    end
                end
                OP_START:
                begin
                    running     = 1'b1;
                    groups_left = cnt;
                    pulse_num   = '0;
                    changed     = !level;
                    level       = 1'b1;
                    next_change = now + timing.pulse_on_time;
                end
                OP_STOP:
                begin
                    clear_pattern();
                    changed = level;
                    level   = 1'b0;
                end
                default: ;
            endcase
            res.buzzer_on       = level;
            res.output_changed  = changed;
            res.pattern_running = running;
            return res;
        endfunction

        function void take_command(logic [1:0] op, logic [TIME_W-1:0] now,
                                   logic [GROUP_W-1:0] cnt);
            expected_levels.push_back(advance_pattern(op, now, cnt));
        endfunction

        function void check_levels(result_t got);
            result_t want;
            if (expected_levels.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: buzzer_on %0b changed %0b running %0b",
                         $time, got.buzzer_on, got.output_changed, got.pattern_running);
                return;
            end
            want = expected_levels.pop_front();
            if (got.buzzer_on !== want.buzzer_on)
            begin
                errors++;
                $display("%0t: buzzer_on expected %0b actual %0b",
                         $time, want.buzzer_on, got.buzzer_on);
            end
            if (got.output_changed !== want.output_changed)
            begin
                errors++;
                $display("%0t: output_changed expected %0b actual %0b",
                         $time, want.output_changed, got.output_changed);
            end
            if (got.pattern_running !== want.pattern_running)
            begin
                errors++;
                $display("%0t: pattern_running expected %0b actual %0b",
                         $time, want.pattern_running, got.pattern_running);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [DUR_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [TIME_W-1:0]  now_ms;
    logic [GROUP_W-1:0] group_count;
    logic               out_valid;
    logic               out_ready;
    logic               buzzer_on;
    logic               output_changed;
    logic               pattern_running;

    pulse_pattern_tracker tracker = new();
    logic [TIME_W-1:0]    clock_ms;
    bit                   gapless;
    bit                   hold_req;
    int unsigned          stalled_cycles;

    buzzer_pulse_group_sequencer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .now_ms          (now_ms),
        .group_count     (group_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .buzzer_on       (buzzer_on),
        .output_changed  (output_changed),
        .pattern_running (pattern_running)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = gapless ? 0 : $urandom_range(0, 13);
            if (hold_req)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            tracker.check_levels('{buzzer_on, output_changed, pattern_running});
            @(negedge clk);
        end
    end

    // Offer one command and wait for its transfer; entered and left at a falling edge
    task automatic send_cmd(logic [1:0] op, logic [TIME_W-1:0] now, logic [GROUP_W-1:0] cnt);
        int unsigned gap;
        gap = gapless ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        now_ms      <= now;
        group_count <= cnt;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_command(op, now, cnt);
        @(negedge clk);
    endtask

    // Drop valid and let the block run empty
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.expected_levels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [DUR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_timing(logic [DUR_W-1:0] on_ms, logic [DUR_W-1:0] gap_ms,
                                logic [DUR_W-1:0] pause_ms, logic [DUR_W-1:0] pulses);
        write_reg(CFG_PULSE_ON, on_ms);
        write_reg(CFG_PULSE_GAP, gap_ms);
        write_reg(CFG_GROUP_PAUSE, pause_ms);
        write_reg(CFG_PULSES, pulses);
    endtask

    // Mostly well-formed patterns: starts when idle, polls walking forward in time
    task automatic random_phase(int unsigned count, int unsigned scale);
        int unsigned      pick;
        logic [GROUP_W-1:0] cnt;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                gapless = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            cnt  = GROUP_W'($urandom());
            if (pick < (tracker.running ? 1 : 30))
            begin
                if ($urandom_range(0, 7) != 0)
                    cnt = GROUP_W'($urandom_range(0, 3));
                clock_ms += $urandom_range(0, scale);
                send_cmd(OP_START, clock_ms, cnt);
            end
            else if (pick < 32)
                send_cmd(OP_STOP, $urandom(), cnt);
            else if (pick < 34)
                send_cmd(OP_UNUSED, $urandom(), cnt);
            else if (pick < 39)
                send_cmd(OP_POLL, $urandom(), cnt);
            else
            begin
                clock_ms += $urandom_range(0, scale);
                send_cmd(OP_POLL, clock_ms, cnt);
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        opcode      = OP_POLL;
        now_ms      = '0;
        group_count = '0;
        gapless     = 1'b0;
        hold_req    = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset timing: idle commands, one group across the time wrap, restart, stop
        send_cmd(OP_POLL, 32'h0000_0000, 8'h00);
        send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
        send_cmd(OP_STOP, 32'h0000_0000, 8'h00);
        send_cmd(OP_START, 32'hFFFF_FFC0, 8'd1);
        send_cmd(OP_POLL, 32'hFFFF_FFFF, 8'hFF);
        send_cmd(OP_POLL, 32'h0000_0024, 8'h00);
        send_cmd(OP_POLL, 32'h0000_0088, 8'h00);
        send_cmd(OP_POLL, 32'h0000_00EC, 8'h00);
        send_cmd(OP_POLL, 32'h0000_0150, 8'h00);
        send_cmd(OP_POLL, 32'h0000_01B4, 8'h00);
        send_cmd(OP_POLL, 32'h0000_2000, 8'h00);
        send_cmd(OP_START, 32'd1000, 8'd0);
        send_cmd(OP_START, 32'd1050, 8'd0);
        send_cmd(OP_POLL, 32'd1150, 8'h00);
        send_cmd(OP_POLL, 32'd1250, 8'h00);
        send_cmd(OP_POLL, 32'd1350, 8'h00);
        send_cmd(OP_POLL, 32'd1450, 8'h00);
        send_cmd(OP_POLL, 32'd1550, 8'h00);
        send_cmd(OP_POLL, 32'd2050, 8'h00);
        send_cmd(OP_STOP, 32'd2060, 8'h00);
        send_cmd(OP_START, 32'd3000, 8'hFF);
        send_cmd(OP_UNUSED, 32'd3050, 8'h00);
        send_cmd(OP_POLL, 32'd3100, 8'h00);
        send_cmd(OP_STOP, 32'd3200, 8'h00);
        clock_ms = 32'd4000;
        random_phase(PHASE_ITEMS, 600);

        // Shortest times, one pulse per group
        write_timing(16'd1, 16'd1, 16'd1, 16'd1);
        clock_ms = 32'hFFFF_FF00;
        random_phase(PHASE_ITEMS, 2);

        // Longest times, most pulses; upper data bits ignored for the pulse count
        write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        clock_ms = 32'hFF90_0000;
        random_phase(PHASE_ITEMS, 65535);

        // Zero times and zero pulses per group, across the sign boundary
        write_timing(16'd0, 16'd0, 16'd0, 16'hABC0);
        clock_ms = 32'h7FFF_FFF0;
        random_phase(PHASE_ITEMS, 3);

        // Random moderate timing, with a long hold on the result side
        write_timing(DUR_W'($urandom_range(1, 40)), DUR_W'($urandom_range(1, 40)),
                     DUR_W'($urandom_range(1, 100)), DUR_W'($urandom_range(1, 5)));
        clock_ms = $urandom();
        hold_req = 1'b1;
        random_phase(PHASE_ITEMS, 100);

        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.expected_levels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
